// ===== src/rdt_pkg.sv =====
package rdt_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;

    localparam int NOW_W     = 32;
    localparam int TIMEOUT_W = 32;
    localparam int ACCUM_W   = 8;
    localparam int DETENT_W  = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_TIMEOUT_ENABLE = 1'b0;
    localparam logic REG_TIMEOUT_MS     = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RESET = {TIMEOUT_W{1'b1}};

    localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = 8'sd127;
    localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = -8'sd128;

    typedef logic signed [1:0] quad_step_t;

    localparam quad_step_t QUAD_TABLE [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0,
        2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1,
        2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

endpackage

// ===== src/rotary_encoder_detent_tracker_core.sv =====
// Channel   Direction  Word bits (lowest first)
// s_axis    in         tuser: command; tdata: pin_a, pin_b, button_level, now_ms, zero pad
// m_axis    out        tdata: detent_steps, press_edge, sleep_request
// cfg       in         cfg_index 0 timeout_enable, 1 timeout_ms; written when cfg_wen is high
//
// A tick result is in the output register in the cycle after its word is accepted.
// A new word is accepted each cycle while the output register is empty or being drained.
// Sample words produce no result but wait with the rest when the output is stalled.
// Reset clears the encoder state, the accumulator, the button history and the activity time.
module rotary_encoder_detent_tracker_core #(
    parameter int TIME_WIDTH = rdt_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pin_a, pin_b, button_level, now_ms[31:0], zero pad
    input  logic [rdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // detent_steps[5:0], press_edge, sleep_request
    output logic [rdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_wen,
    input  logic                           cfg_index,
    input  logic [rdt_pkg::TIMEOUT_W-1:0]  cfg_data
);

    localparam int CMP_W = (TIME_WIDTH > rdt_pkg::NOW_W) ? TIME_WIDTH : rdt_pkg::NOW_W;

    logic                                 timeout_enable_reg;
    logic [rdt_pkg::TIMEOUT_W-1:0]        timeout_ms_reg;
    logic [1:0]                           quad_prev_reg;
    logic [1:0]                           quad_prev_next;
    logic signed [rdt_pkg::ACCUM_W-1:0]   step_accum_reg;
    logic signed [rdt_pkg::ACCUM_W-1:0]   step_accum_next;
    logic                                 button_was_down_reg;
    logic                                 button_was_down_next;
    logic [TIME_WIDTH-1:0]                last_activity_reg;
    logic [TIME_WIDTH-1:0]                last_activity_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [rdt_pkg::OUT_DATA_W-1:0]       out_data_reg;
    logic [rdt_pkg::OUT_DATA_W-1:0]       out_data_next;

    logic                                 accept;
    logic                                 pin_a;
    logic                                 pin_b;
    logic                                 button_level;
    logic [rdt_pkg::NOW_W-1:0]            now_ms;
    logic [1:0]                           quad_now;
    rdt_pkg::quad_step_t                  quad_step;
    logic signed [rdt_pkg::ACCUM_W:0]     accum_diff;
    logic signed [rdt_pkg::DETENT_W-1:0]  detents;
    logic                                 pressed;
    logic                                 press_edge;
    logic                                 activity;
    logic [CMP_W-1:0]                     now_wide;
    logic [TIME_WIDTH-1:0]                now_time;
    logic [TIME_WIDTH-1:0]                idle_time;
    logic                                 sleep_request;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign pin_a        = s_axis_tdata[0];
    assign pin_b        = s_axis_tdata[1];
    assign button_level = s_axis_tdata[2];
    assign now_ms       = s_axis_tdata[rdt_pkg::NOW_W+2:3];

    assign quad_now   = {pin_a, pin_b};
    assign quad_step  = rdt_pkg::QUAD_TABLE[{quad_prev_reg, quad_now}];
    assign accum_diff = (rdt_pkg::ACCUM_W+1)'(step_accum_reg)
                      - (rdt_pkg::ACCUM_W+1)'(quad_step);

    assign detents    = step_accum_reg[rdt_pkg::ACCUM_W-1:2];
    assign pressed    = !button_level;
    assign press_edge = pressed && !button_was_down_reg;
    assign activity   = (detents != '0) || press_edge;
    assign now_wide   = CMP_W'(now_ms);
    assign now_time   = now_wide[TIME_WIDTH-1:0];
    assign idle_time  = activity ? '0 : (now_time - last_activity_reg);
    assign sleep_request = timeout_enable_reg
                        && (CMP_W'(idle_time) > CMP_W'(timeout_ms_reg));

    always_comb
    begin
        quad_prev_next       = quad_prev_reg;
        step_accum_next      = step_accum_reg;
        button_was_down_next = button_was_down_reg;
        last_activity_next   = last_activity_reg;
        out_valid_next       = out_valid_reg && !m_axis_tready;
        out_data_next        = out_data_reg;
        if (accept)
        begin
            unique case (s_axis_tuser)
                rdt_pkg::CMD_SAMPLE:
                begin
                    quad_prev_next = quad_now;
                    if (accum_diff > (rdt_pkg::ACCUM_W+1)'(rdt_pkg::ACCUM_MAX))
                    begin
                        step_accum_next = rdt_pkg::ACCUM_MAX;
                    end
                    else if (accum_diff < (rdt_pkg::ACCUM_W+1)'(rdt_pkg::ACCUM_MIN))
                    begin
                        step_accum_next = rdt_pkg::ACCUM_MIN;
                    end
                    else
                    begin
                        step_accum_next = accum_diff[rdt_pkg::ACCUM_W-1:0];
                    end
                end
                rdt_pkg::CMD_TICK:
                begin
                    step_accum_next      = {{(rdt_pkg::ACCUM_W-2){1'b0}}, step_accum_reg[1:0]};
                    button_was_down_next = pressed;
                    if (activity)
                    begin
                        last_activity_next = now_time;
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {sleep_request, press_edge, detents};
                end
                default:
                begin
                    quad_prev_next = quad_prev_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_enable_reg  <= 1'b0;
            timeout_ms_reg      <= rdt_pkg::TIMEOUT_MS_RESET;
            quad_prev_reg       <= '0;
            step_accum_reg      <= '0;
            button_was_down_reg <= 1'b0;
            last_activity_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    rdt_pkg::REG_TIMEOUT_ENABLE: timeout_enable_reg <= cfg_data[0];
                    rdt_pkg::REG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data;
                    default:                     timeout_enable_reg <= timeout_enable_reg;
                endcase
            end
            quad_prev_reg       <= quad_prev_next;
            step_accum_reg      <= step_accum_next;
            button_was_down_reg <= button_was_down_next;
            last_activity_reg   <= last_activity_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== dv/rotary_encoder_detent_tracker_core_test.sv =====
`timescale 1ns / 1ps

module rotary_encoder_detent_tracker_core_test;

    import rdt_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_WORDS = 14;
    localparam int SPIN_STEPS  = 140;

    localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    // Gray-code successor of the pin state {a, b} in each turning direction.
    localparam logic [1:0] CW_NEXT  [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
    localparam logic [1:0] CCW_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

    typedef struct packed {
        logic signed [DETENT_W-1:0] detent_steps;
        logic                       press_edge;
        logic                       sleep_request;
    } tick_result_t;

    class detent_scoreboard;
        logic [1:0]                quad_prev;
        logic signed [ACCUM_W-1:0] step_accum;
        logic                      button_was_down;
        logic [NOW_W-1:0]          last_activity_ms;
        logic                      timeout_enable;
        logic [TIMEOUT_W-1:0]      timeout_ms;
        tick_result_t              expected_q[$];
        int errors;
        int results;
        int press_edges;
        int sleep_requests;
        int clamps;

        function new();
            quad_prev        = '0;
            step_accum       = '0;
            button_was_down  = 1'b0;
            last_activity_ms = '0;
            timeout_enable   = 1'b0;
            timeout_ms       = TIMEOUT_MS_RESET;
            errors           = 0;
            results          = 0;
            press_edges      = 0;
            sleep_requests   = 0;
            clamps           = 0;
        endfunction

        function void write_register(logic index, logic [TIMEOUT_W-1:0] value);
            if (index == REG_TIMEOUT_ENABLE)
                timeout_enable = value[0];
            else if (index == REG_TIMEOUT_MS)
                timeout_ms = value;
        endfunction

        function void note_word(logic cmd, logic pin_a, logic pin_b, logic level,
                                logic [NOW_W-1:0] now);
            logic [1:0]                pin_state;
            int                        sum;
            logic                      pressed;
            logic signed [ACCUM_W-1:0] whole;
            logic [NOW_W-1:0]          idle;
            tick_result_t              res;
            if (cmd == CMD_SAMPLE)
            begin
                pin_state = {pin_a, pin_b};
                sum = int'(step_accum) - QUAD_STEP[{quad_prev, pin_state}];
                if (sum > 127)
                begin
                    sum = 127;
                    clamps++;
                end
                else if (sum < -128)
                begin
                    sum = -128;
                    clamps++;
                end
                step_accum = sum[ACCUM_W-1:0];
                quad_prev  = pin_state;
                return;
            end
            pressed = ~level;
            res.press_edge = pressed & ~button_was_down;
            button_was_down = pressed;
            whole = step_accum >>> 2;
            step_accum = {{(ACCUM_W-2){1'b0}}, step_accum[1:0]};
            res.detent_steps = whole[DETENT_W-1:0];
            if (whole != 0 || res.press_edge)
                last_activity_ms = now;
            idle = now - last_activity_ms;
            res.sleep_request = timeout_enable && (idle > timeout_ms);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            tick_result_t want;
            tick_result_t got;
            got = {data[5:0], data[6], data[7]};
            if (expected_q.size() == 0)
            begin
                $error("result %h arrived with no tick outstanding", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (got.press_edge)
                press_edges++;
            if (got.sleep_request)
                sleep_requests++;
            if (got.detent_steps != want.detent_steps)
            begin
                $error("detent_steps: expected %0d, actual %0d",
                       want.detent_steps, got.detent_steps);
                errors++;
            end
            if (got.press_edge != want.press_edge)
            begin
                $error("press_edge: expected %0b, actual %0b", want.press_edge, got.press_edge);
                errors++;
            end
            if (got.sleep_request != want.sleep_request)
            begin
                $error("sleep_request: expected %0b, actual %0b",
                       want.sleep_request, got.sleep_request);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = CMD_SAMPLE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wen = 1'b0;
    logic                  cfg_index = REG_TIMEOUT_ENABLE;
    logic [TIMEOUT_W-1:0]  cfg_data = '0;

    detent_scoreboard      sb;
    int                    cycle_count = 0;
    int                    words_sent = 0;
    bit                    sender_waits = 1'b1;
    bit                    receiver_waits = 1'b1;
    logic [1:0]            pins = 2'b00;
    logic                  button = 1'b1;
    logic [NOW_W-1:0]      clock_ms = '0;
    logic [OUT_DATA_W-1:0] result_word;

    rotary_encoder_detent_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // The check runs just after the edge so that words accepted at the same
    // edge have already reached the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_word = m_axis_tdata;
            #1;
            sb.check_result(result_word);
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            stall = receiver_waits ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_word(logic cmd, logic pin_a, logic pin_b, logic level,
                             logic [NOW_W-1:0] now);
        int gap;
        gap = sender_waits ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, now, level, pin_b, pin_a};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_word(cmd, pin_a, pin_b, level, now);
        words_sent++;
    endtask

    task automatic turn_step(bit cw);
        pins = cw ? CW_NEXT[pins] : CCW_NEXT[pins];
        send_word(CMD_SAMPLE, pins[1], pins[0], 1'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic tick_word();
        if ($urandom_range(0, 15) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 3) == 0)
            button = ~button;
        send_word(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), button,
                  clock_ms);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_timeout(logic enable, logic [TIMEOUT_W-1:0] limit_ms);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_TIMEOUT_ENABLE;
        cfg_data  <= {{(TIMEOUT_W-1){1'b0}}, enable};
        @(posedge clk);
        sb.write_register(REG_TIMEOUT_ENABLE, {{(TIMEOUT_W-1){1'b0}}, enable});
        cfg_index <= REG_TIMEOUT_MS;
        cfg_data  <= limit_ms;
        @(posedge clk);
        sb.write_register(REG_TIMEOUT_MS, limit_ms);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        logic             phase_enable [PHASE_COUNT];
        logic [NOW_W-1:0] phase_limit [PHASE_COUNT];
        int               start;
        int               burst;
        bit               cw;
        int               pick;
        sb = new();
        phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_limit  = '{32'd0, 32'd25, 32'hFFFF_FFFF, 32'd0, 32'd300, 32'd1};
        phase_limit[4] = $urandom_range(10, 60);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short directed pass with the reset settings.
        send_word(CMD_TICK, 1'b0, 1'b0, 1'b1, 32'd0);
        send_word(CMD_SAMPLE, 1'b0, 1'b1, 1'b0, 32'd0);
        send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd0);
        send_word(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 32'd0);
        send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd0);
        send_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(CMD_SAMPLE, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 1'b1, 1'b1, 1'b0, 32'd5);
        send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 32'd7);
        send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 32'd9);
        send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 32'd11);
        send_word(CMD_SAMPLE, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_word(CMD_TICK, 1'b1, 1'b0, 1'b1, 32'd0);
        send_word(CMD_TICK, 1'b0, 1'b1, 1'b1, 32'h8000_0000);
        send_word(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF);
        pins     = 2'b01;
        button   = 1'b1;
        clock_ms = 32'h7FFF_FFFF;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_for_results();
            set_timeout(phase_enable[phase], phase_limit[phase]);
            sender_waits   = (phase != 2);
            receiver_waits = (phase != 2);
            if (phase == 3)
            begin
                // Turn far enough in each direction to hit both clamps.
                repeat (SPIN_STEPS) turn_step(1'b1);
                repeat (2) tick_word();
                repeat (SPIN_STEPS) turn_step(1'b0);
                repeat (2) tick_word();
            end
            if (phase == 5)
                clock_ms = 32'hFFFF_FFC0;
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)
                begin
                    cw = 1'($urandom_range(0, 1));
                    burst = $urandom_range(1, 12);
                    repeat (burst) turn_step(cw);
                    if ($urandom_range(0, 1) == 1)
                        tick_word();
                end
                else if (pick <= 7)
                    tick_word();
                else if (pick == 8)
                begin
                    pins = 2'($urandom_range(0, 3));
                    send_word(CMD_SAMPLE, pins[1], pins[0], 1'($urandom_range(0, 1)),
                              $urandom());
                end
                else
                begin
                    cw = 1'($urandom_range(0, 1));
                    turn_step(cw);
                    turn_step(~cw);
                end
            end
            tick_word();
        end

        wait_for_results();
        repeat (5) @(posedge clk);
        $display("Sent %0d words over %0d timeout settings; %0d tick results checked.",
                 words_sent, PHASE_COUNT + 1, sb.results);
        $display("Saw %0d press edges, %0d sleep requests and %0d accumulator clamps.",
                 sb.press_edges, sb.sleep_requests, sb.clamps);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
